// ----- rtl/sld_pkg.sv -----
// Shared types, register map and codes for the STX/length/ETX deframer.
package sld_pkg;

   localparam int TIMER_WIDTH = 16;
   localparam int TIMEOUT_W   = 16;
   localparam int CMP_W       = (TIMER_WIDTH > TIMEOUT_W) ? TIMER_WIDTH : TIMEOUT_W;
   localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = '1;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      REG_START_BYTE    = 2'd0,
      REG_END_BYTE      = 2'd1,
      REG_MAX_LENGTH    = 2'd2,
      REG_TIMEOUT_TICKS = 2'd3
   } reg_idx_type;

   localparam logic [7:0]           RST_START_BYTE    = 8'h02;
   localparam logic [7:0]           RST_END_BYTE      = 8'h03;
   localparam logic [7:0]           RST_MAX_LENGTH    = 8'd66;
   localparam logic [TIMEOUT_W-1:0] RST_TIMEOUT_TICKS = 16'd100;

   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   localparam logic KIND_BODY = 1'b0;
   localparam logic KIND_END  = 1'b1;

   localparam logic [1:0] STATUS_GOOD    = 2'd0;
   localparam logic [1:0] STATUS_BAD_END = 2'd1;
   localparam logic [1:0] STATUS_LENGTH  = 2'd2;
   localparam logic [1:0] STATUS_TIMEOUT = 2'd3;

   typedef enum logic [3:0] {
      PH_START = 4'b0001,
      PH_LEN   = 4'b0010,
      PH_BODY  = 4'b0100,
      PH_END   = 4'b1000
   } phase_type;

   typedef struct packed {
      logic [7:0]           start_byte;
      logic [7:0]           end_byte;
      logic [7:0]           max_length;
      logic [TIMEOUT_W-1:0] timeout_ticks;
   } cfg_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] body_byte;
      logic [7:0] body_index;
      logic [1:0] status;
      logic [7:0] frame_length;
   } rsp_type;

endpackage

// ----- rtl/sld_csr.sv -----
// Configuration register file on the APB-style port.
module sld_csr import sld_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type     cfg_ff, cfg_in;
   reg_idx_type idx;
   logic        wr_en;

   assign csr_pready = 1'b1;
   assign idx   = reg_idx_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign wr_en = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            REG_START_BYTE:    cfg_in.start_byte    = csr_pwdata[7:0];
            REG_END_BYTE:      cfg_in.end_byte      = csr_pwdata[7:0];
            REG_MAX_LENGTH:    cfg_in.max_length    = csr_pwdata[7:0];
            REG_TIMEOUT_TICKS: cfg_in.timeout_ticks = csr_pwdata[TIMEOUT_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_START_BYTE:    csr_prdata = CSR_DATA_W'(cfg_ff.start_byte);
         REG_END_BYTE:      csr_prdata = CSR_DATA_W'(cfg_ff.end_byte);
         REG_MAX_LENGTH:    csr_prdata = CSR_DATA_W'(cfg_ff.max_length);
         REG_TIMEOUT_TICKS: csr_prdata = CSR_DATA_W'(cfg_ff.timeout_ticks);
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_byte    <= RST_START_BYTE;
         cfg_ff.end_byte      <= RST_END_BYTE;
         cfg_ff.max_length    <= RST_MAX_LENGTH;
         cfg_ff.timeout_ticks <= RST_TIMEOUT_TICKS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/sld_core.sv -----
// Frame state machine and idle timer; one item per advance.
module sld_core import sld_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  logic       cmd,
   input  logic [7:0] rx_byte,
   input  cfg_type    cfg,
   output logic       res_valid,
   output rsp_type    res
);

   phase_type              phase_ff, phase_in;
   logic [7:0]             exp_len_ff, exp_len_in;
   logic [7:0]             taken_ff, taken_in;
   logic                   armed_ff, armed_in;
   logic [TIMER_WIDTH-1:0] idle_ff, idle_in;

   logic [CMP_W-1:0]       limit;
   logic [CMP_W-1:0]       ticks_ext;
   logic [TIMER_WIDTH-1:0] idle_sat;
   logic [7:0]             taken_inc;

   // effective limit: zero acts as one, clamp to counter range
   always_comb begin
      ticks_ext = CMP_W'(cfg.timeout_ticks);
      if (ticks_ext == '0)
         limit = CMP_W'(1);
      else if (ticks_ext > CMP_W'(TIMER_MAX))
         limit = CMP_W'(TIMER_MAX);
      else
         limit = ticks_ext;
   end

   assign idle_sat  = (idle_ff == TIMER_MAX) ? idle_ff : idle_ff + 1'b1;
   assign taken_inc = taken_ff + 8'd1;

   always_comb begin
      phase_in   = phase_ff;
      exp_len_in = exp_len_ff;
      taken_in   = taken_ff;
      armed_in   = armed_ff;
      idle_in    = idle_ff;
      res_valid  = 1'b0;
      res        = '{kind: KIND_END, body_byte: '0, body_index: '0,
                     status: STATUS_GOOD, frame_length: '0};

      if (cmd == CMD_TICK) begin
         if (armed_ff) begin
            if (CMP_W'(idle_sat) >= limit) begin
               phase_in   = PH_START;
               exp_len_in = '0;
               taken_in   = '0;
               armed_in   = 1'b0;
               idle_in    = '0;
               res_valid  = 1'b1;
               res.status = STATUS_TIMEOUT;
            end else begin
               idle_in = idle_sat;
            end
         end
      end else begin
         armed_in = 1'b1;
         idle_in  = '0;
         case (phase_ff)
            PH_START: begin
               if (rx_byte == cfg.start_byte) begin
                  exp_len_in = '0;
                  taken_in   = '0;
                  phase_in   = PH_LEN;
               end
            end
            PH_LEN: begin
               if (rx_byte > cfg.max_length) begin
                  phase_in   = PH_START;
                  exp_len_in = '0;
                  taken_in   = '0;
                  armed_in   = 1'b0;
                  res_valid  = 1'b1;
                  res.status = STATUS_LENGTH;
               end else begin
                  exp_len_in = rx_byte;
                  taken_in   = '0;
                  phase_in   = (rx_byte == 8'd0) ? PH_END : PH_BODY;
               end
            end
            PH_BODY: begin
               res_valid      = 1'b1;
               res.kind       = KIND_BODY;
               res.body_byte  = rx_byte;
               res.body_index = taken_ff;
               taken_in       = taken_inc;
               if (taken_inc == exp_len_ff)
                  phase_in = PH_END;
            end
            default: begin
               phase_in   = PH_START;
               exp_len_in = '0;
               taken_in   = '0;
               armed_in   = 1'b0;
               res_valid  = 1'b1;
               if (rx_byte == cfg.end_byte) begin
                  res.status       = STATUS_GOOD;
                  res.frame_length = exp_len_ff;
               end else begin
                  res.status = STATUS_BAD_END;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_START;
         exp_len_ff <= '0;
         taken_ff   <= '0;
         armed_ff   <= 1'b0;
         idle_ff    <= '0;
      end else if (advance) begin
         phase_ff   <= phase_in;
         exp_len_ff <= exp_len_in;
         taken_ff   <= taken_in;
         armed_ff   <= armed_in;
         idle_ff    <= idle_in;
      end
   end

endmodule

// ----- rtl/sld_out.sv -----
// Result register holding one transfer until the receiver takes it.
module sld_out import sld_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  rsp_type res,
   input  logic    rsp_ready,
   output logic    rsp_valid,
   output rsp_type rsp
);

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   assign valid_in = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset)
         valid_ff <= 1'b0;
      else
         valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (load)
         data_ff <= res;
   end

   assign rsp_valid = valid_ff;
   assign rsp       = data_ff;

endmodule

// ----- rtl/stx_length_etx_deframer.sv -----
// Top level of the STX/length/ETX frame receiver.
//
// Input channel (req_): one transfer per received byte (req_cmd = 0) or per
// timer tick (req_cmd = 1). Result channel (rsp_): body bytes with their
// index (rsp_kind = 0) and frame end reports (rsp_kind = 1) with status
// good, bad end byte, length too large or timeout.
// A transfer is captured in an input register; when it advances, the state
// machine updates and any result lands in the output register. One item
// per cycle is sustained while rsp_ready stays high: the input register
// refills in the same cycle it drains. When rsp_ready is low with a result
// waiting, the state machine holds the pending input item and req_ready
// drops once the input register is full; nothing is dropped. Items that
// produce no result advance as long as the output register is free or
// being emptied. Reset (synchronous, active high) returns the hunt for the
// start byte, disarms the idle timer, empties both registers and restores
// the default register values. Configuration is to be written through the
// csr_ port only while no item is in flight; the block itself does not
// enforce this.
module stx_length_etx_deframer import sld_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_cmd,
   input  logic [7:0]            req_rx_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_kind,
   output logic [7:0]            rsp_body_byte,
   output logic [7:0]            rsp_body_index,
   output logic [1:0]            rsp_status,
   output logic [7:0]            rsp_frame_length,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type    cfg;
   logic       in_valid_ff, in_valid_in;
   logic       in_cmd_ff;
   logic [7:0] in_byte_ff;
   logic       advance;
   logic       res_valid;
   rsp_type    res;
   rsp_type    rsp;

   sld_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // item moves on when the output slot is free or drains this cycle
   assign advance     = in_valid_ff && (!rsp_valid || rsp_ready);
   assign req_ready   = !in_valid_ff || advance;
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset)
         in_valid_ff <= 1'b0;
      else
         in_valid_ff <= in_valid_in;
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_cmd_ff  <= req_cmd;
         in_byte_ff <= req_rx_byte;
      end
   end

   sld_core u_core (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .cmd       (in_cmd_ff),
      .rx_byte   (in_byte_ff),
      .cfg       (cfg),
      .res_valid (res_valid),
      .res       (res)
   );

   sld_out u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && res_valid),
      .res       (res),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   assign rsp_kind         = rsp.kind;
   assign rsp_body_byte    = rsp.body_byte;
   assign rsp_body_index   = rsp.body_index;
   assign rsp_status       = rsp.status;
   assign rsp_frame_length = rsp.frame_length;

   // a waiting result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !(advance && res_valid))
      else $error("result register overwritten while stalled");

   // empty pipeline always takes input
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && !in_valid_ff |-> req_ready)
      else $error("input stalled with empty pipeline");

   // body transfers carry no status or length
   a_body_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_BODY |->
         rsp_status == STATUS_GOOD && rsp_frame_length == 8'd0)
      else $error("body transfer with frame end fields set");

   // a loaded result shows up in the next cycle
   a_load_visible: assert property (@(posedge clock) disable iff (reset)
      advance && res_valid |=> rsp_valid)
      else $error("loaded result not presented");

endmodule
